>>> rtl/ppwp_pkg.sv
// package for the piecewise polynomial wheel profile unit
// shared constants, types and status codes; no dependencies
package ppwp_pkg;

    localparam int MaxEntriesDefault = 16;
    localparam int SlotWidth = 4;

    typedef enum logic [1:0] {
        STATUS_TICK    = 2'd0,
        STATUS_STORED  = 2'd1,
        STATUS_BAD_END = 2'd2,
        STATUS_BAD_MID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_CONST = 2'd0,
        KIND_LINEAR = 2'd1,
        KIND_QUAD  = 2'd2,
        KIND_SPARE = 2'd3
    } kind_t;

    // request and reply between sequencer and ratio unit
    typedef struct packed {
        logic        go;
        logic        neg;
        logic [63:0] num;
        logic [63:0] den;
        logic [31:0] mag_y;
    } ratio_req_t;

    typedef struct packed {
        logic        done;
        logic [41:0] value;
    } ratio_rsp_t;

    // entry record width: start, end, first, last, mid_t, mid_v
    localparam int EntryWidth = 6 * 32;

endpackage

>>> rtl/ppwp_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module ppwp_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ppwp_ratio.sv
// ratio unit: y*num/den truncated, magnitude capped at 2^40, signed result
// shift-add multiply of num by |y| then restoring divide, one bit a cycle
// depends on ppwp_pkg
module ppwp_ratio (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppwp_pkg::ratio_req_t req,
    output ppwp_pkg::ratio_rsp_t rsp
);
    import ppwp_pkg::*;

    typedef enum logic [1:0] {
        R_IDLE,
        R_MUL,
        R_DIV
    } rstate_t;

    localparam logic [63:0] Limit = 64'd1 << 40;

    rstate_t      state_reg;
    logic [6:0]   cnt_reg;
    logic [95:0]  prod_reg;
    logic [63:0]  num_reg;
    logic [31:0]  y_reg;
    logic [63:0]  den_reg;
    logic [63:0]  rem_reg;
    logic [95:0]  quo_reg;
    logic         neg_reg;
    logic         done_reg;
    logic [41:0]  value_reg;

    logic [64:0]  rem_sh;
    logic         take;
    logic [95:0]  quo_sh;
    logic [63:0]  mag;

    // one restoring divide step
    always_comb
    begin
        rem_sh = {rem_reg, prod_reg[95]};
        take   = (rem_sh >= {1'b0, den_reg});
        quo_sh = {quo_reg[94:0], take};
        if (quo_sh[95:64] != 32'd0 || quo_sh[63:0] > Limit)
        begin
            mag = Limit;
        end
        else
        begin
            mag = quo_sh[63:0];
        end
    end

    // sequencer for multiply then divide
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                R_IDLE:
                begin
                    if (req.go)
                    begin
                        num_reg  <= req.num;
                        y_reg    <= req.mag_y;
                        den_reg  <= req.den;
                        neg_reg  <= req.neg;
                        prod_reg <= '0;
                        cnt_reg  <= 7'd31;
                        if (req.den == 64'd0)
                        begin
                            value_reg <= '0;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= R_MUL;
                        end
                    end
                end
                R_MUL:
                begin
                    prod_reg <= {prod_reg[94:0], 1'b0}
                        + (y_reg[cnt_reg[4:0]] ? {32'd0, num_reg} : 96'd0);
                    if (cnt_reg == 7'd0)
                    begin
                        cnt_reg   <= 7'd95;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        state_reg <= R_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                R_DIV:
                begin
                    rem_reg  <= take ? rem_sh[63:0] - den_reg : rem_sh[63:0];
                    quo_reg  <= quo_sh;
                    prod_reg <= {prod_reg[94:0], 1'b0};
                    if (cnt_reg == 7'd0)
                    begin
                        value_reg <= neg_reg ? 42'(-{1'b0, mag[40:0]}) : {1'b0, mag[40:0]};
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

`ifndef SYNTHESIS
    a_done_from_idle_or_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == R_IDLE || $past(state_reg) == R_DIV)
        else $error("ratio done outside final step");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !neg_reg |-> value_reg <= 42'(Limit))
        else $error("ratio magnitude above cap");
    a_busy_no_go: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == R_MUL |=> state_reg != R_IDLE)
        else $error("multiply phase left early");
`endif

endmodule

>>> rtl/piecewise_poly_wheel_profile_unit.sv
// top level of the piecewise polynomial wheel profile unit
// depends on ppwp_pkg, ppwp_ram, ppwp_ratio
//
// Command port: an item transfers when start is high and busy is low; the
// single result is shown for one cycle with done high and cannot be held off.
// A new item may transfer in the cycle that shows the result. A load keeps
// busy high for 1 cycle. A tick walks every slot in turn (read, wait, check,
// next), then writes each wheel's output in a final step. Each ratio runs
// through one shared ratio unit: two operand multiplies, a handoff, 32
// multiply steps, 96 divide steps, and taking the result. A linear entry in
// range needs one ratio and a quadratic one three ratios plus a sum step.
// The table sits in one ram read a slot per step; valid bits live in
// flip-flops cleared by reset.
module piecewise_poly_wheel_profile_unit #(
    parameter int MAX_ENTRIES = ppwp_pkg::MaxEntriesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        mode,
    input  logic [3:0]  slot,
    input  logic [1:0]  wheel_sel,
    input  logic [1:0]  curve_kind,
    input  logic        entry_enable,
    input  logic [31:0] start_time,
    input  logic [31:0] end_time,
    input  logic [31:0] first_value,
    input  logic [31:0] last_value,
    input  logic [31:0] mid_time,
    input  logic [31:0] mid_value,
    input  logic [31:0] now_time,
    output logic [1:0]  status,
    output logic [31:0] vel_front_left,
    output logic [31:0] vel_front_right,
    output logic [31:0] vel_rear_left,
    output logic [31:0] vel_rear_right,
    output logic        saturated
);
    import ppwp_pkg::*;

    localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CntW = $clog2(MAX_ENTRIES + 1);
    localparam logic signed [47:0] Max32 = 48'sd2147483647;
    localparam logic signed [47:0] Min32 = -48'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_CHECK,
        S_TERM,
        S_TWAIT,
        S_QSUM,
        S_NEXT,
        S_FINAL,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic             done_reg;
    logic [1:0]       status_reg;
    logic [31:0]      vel_reg [4];
    logic             sat_reg;
    logic [31:0]      now_reg;
    logic [CntW-1:0]  idx_reg;
    logic [1:0]       term_reg;
    logic signed [47:0] sum_reg [4];
    logic signed [47:0] qacc_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [1:0]       wheel_reg [MAX_ENTRIES];
    logic [1:0]       kind_reg [MAX_ENTRIES];

    // table ram
    logic                 ram_we;
    logic [IdxW-1:0]      ram_waddr;
    logic [IdxW-1:0]      ram_raddr;
    logic [EntryWidth-1:0] ram_wdata;
    logic [EntryWidth-1:0] ram_rdata;

    ppwp_ram #(
        .Width(EntryWidth),
        .Depth(MAX_ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    logic [IdxW-1:0] cur;
    logic [IdxW-1:0] wslot;
    assign cur       = idx_reg[IdxW-1:0];
    assign wslot     = IdxW'(slot);
    assign ram_raddr = cur;
    assign ram_waddr = wslot;
    assign ram_wdata = {start_time, end_time, first_value, last_value, mid_time, mid_value};

    // load checks
    status_t ld_status;
    logic    ld_store;
    logic    slot_ok;
    always_comb
    begin
        ld_status = STATUS_STORED;
        ld_store  = 1'b0;
        if (entry_enable)
        begin
            if (end_time <= start_time)
            begin
                ld_status = STATUS_BAD_END;
            end
            else if (curve_kind == KIND_QUAD
                     && !(mid_time > start_time && mid_time < end_time))
            begin
                ld_status = STATUS_BAD_MID;
            end
            else
            begin
                ld_store = 1'b1;
            end
        end
        slot_ok = (32'(slot) < 32'(MAX_ENTRIES));
    end

    logic accept;
    assign accept = start && (state_reg == S_IDLE);
    assign ram_we = accept && !mode && ld_store && slot_ok;

    // entry fields of the slot in view
    logic [31:0] e_t0, e_t1, e_y0, e_y1, e_tm, e_ym;
    assign {e_t0, e_t1, e_y0, e_y1, e_tm, e_ym} = ram_rdata;

    logic signed [33:0] dt0, dtm, dt1;
    assign dt0 = $signed({2'b0, now_reg}) - $signed({2'b0, e_t0});
    assign dtm = $signed({2'b0, now_reg}) - $signed({2'b0, e_tm});
    assign dt1 = $signed({2'b0, now_reg}) - $signed({2'b0, e_t1});

    // operands of the next ratio term
    logic signed [33:0] n1, n2, d1, d2;
    logic signed [32:0] yv;
    always_comb
    begin
        n2 = 34'sd1;
        d2 = 34'sd1;
        if (kind_reg[cur] == KIND_LINEAR)
        begin
            yv = $signed({e_y1[31], e_y1}) - $signed({e_y0[31], e_y0});
            n1 = dt0;
            d1 = $signed({2'b0, e_t1}) - $signed({2'b0, e_t0});
        end
        else
        begin
            case (term_reg)
                2'd0:
                begin
                    yv = $signed({e_y0[31], e_y0});
                    n1 = dtm;
                    n2 = dt1;
                    d1 = $signed({2'b0, e_t0}) - $signed({2'b0, e_tm});
                    d2 = $signed({2'b0, e_t0}) - $signed({2'b0, e_t1});
                end
                2'd1:
                begin
                    yv = $signed({e_ym[31], e_ym});
                    n1 = dt0;
                    n2 = dt1;
                    d1 = $signed({2'b0, e_tm}) - $signed({2'b0, e_t0});
                    d2 = $signed({2'b0, e_tm}) - $signed({2'b0, e_t1});
                end
                default:
                begin
                    yv = $signed({e_y1[31], e_y1});
                    n1 = dt0;
                    n2 = dtm;
                    d1 = $signed({2'b0, e_t1}) - $signed({2'b0, e_t0});
                    d2 = $signed({2'b0, e_t1}) - $signed({2'b0, e_tm});
                end
            endcase
        end
    end

    function automatic logic [31:0] mag34(input logic signed [33:0] v);
        logic [33:0] a;
        a = v[33] ? 34'(-v) : v;
        return a[31:0];
    endfunction

    // operand registers for the ratio unit
    ratio_req_t req_reg;
    ratio_rsp_t rsp;
    logic [31:0] m_n1, m_n2, m_d1, m_d2;
    logic [31:0] m_y;
    assign m_n1 = mag34(n1);
    assign m_n2 = mag34(n2);
    assign m_d1 = mag34(d1);
    assign m_d2 = mag34(d2);
    // the linear difference stays below 2^32 in magnitude
    assign m_y  = yv[32] ? 32'(-yv) : 32'(yv);

    ppwp_ratio u_ratio (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_reg),
        .rsp  (rsp)
    );

    // shared 32 by 32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [47:0] rv, rclamp;
    logic               rsat;
    assign rv = 48'(signed'(rsp.value));
    always_comb
    begin
        rclamp = rv;
        rsat   = 1'b0;
        if (rv > Max32)
        begin
            rclamp = Max32;
            rsat   = 1'b1;
        end
        else if (rv < Min32)
        begin
            rclamp = Min32;
            rsat   = 1'b1;
        end
    end

    logic signed [47:0] qclamp;
    logic               qsat;
    always_comb
    begin
        qclamp = qacc_reg;
        qsat   = 1'b0;
        if (qacc_reg > Max32)
        begin
            qclamp = Max32;
            qsat   = 1'b1;
        end
        else if (qacc_reg < Min32)
        begin
            qclamp = Min32;
            qsat   = 1'b1;
        end
    end

    logic [1:0] wcur;
    assign wcur = wheel_reg[cur];
    logic in_range;
    assign in_range = valid_reg[cur] && now_reg >= e_t0 && now_reg <= e_t1;

    logic [1:0] fin_w;
    logic signed [47:0] fin_v;
    logic [31:0] fin_c;
    logic fin_s;
    assign fin_w = term_reg;
    assign fin_v = sum_reg[fin_w];
    always_comb
    begin
        fin_c = fin_v[31:0];
        fin_s = 1'b0;
        if (fin_v > Max32)
        begin
            fin_c = 32'h7fffffff;
            fin_s = 1'b1;
        end
        else if (fin_v < Min32)
        begin
            fin_c = 32'h80000000;
            fin_s = 1'b1;
        end
    end

    // operand multiply for the product of numerator and denominator pairs
    logic phase_reg;
    always_comb
    begin
        mul_a = phase_reg ? m_d1 : m_n1;
        mul_b = phase_reg ? m_d2 : m_n2;
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            valid_reg  <= '0;
            req_reg.go <= 1'b0;
            phase_reg  <= 1'b0;
            idx_reg    <= '0;
            term_reg   <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            req_reg.go <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!mode)
                        begin
                            if (slot_ok)
                            begin
                                valid_reg[wslot] <= ld_store;
                                wheel_reg[wslot] <= wheel_sel;
                                kind_reg[wslot]  <= curve_kind;
                            end
                            status_reg <= ld_status;
                            vel_reg[0] <= '0;
                            vel_reg[1] <= '0;
                            vel_reg[2] <= '0;
                            vel_reg[3] <= '0;
                            sat_reg    <= 1'b0;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            now_reg    <= now_time;
                            idx_reg    <= '0;
                            sat_reg    <= 1'b0;
                            status_reg <= STATUS_TICK;
                            for (int w = 0; w < 4; w++)
                            begin
                                sum_reg[w] <= '0;
                            end
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    term_reg  <= '0;
                    qacc_reg  <= '0;
                    phase_reg <= 1'b0;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!in_range)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else if (kind_reg[cur] == KIND_LINEAR || kind_reg[cur] == KIND_QUAD)
                    begin
                        state_reg <= S_TERM;
                    end
                    else
                    begin
                        sum_reg[wcur] <= sum_reg[wcur] + 48'(signed'(e_y0));
                        state_reg     <= S_NEXT;
                    end
                end
                S_TERM:
                begin
                    // numerator product first, then denominator product, chosen by phase_reg
                    if (!phase_reg)
                    begin
                        req_reg.num <= mul_p;
                        phase_reg   <= 1'b1;
                    end
                    else
                    begin
                        req_reg.den   <= mul_p;
                        req_reg.neg   <= yv[32] ^ n1[33] ^ n2[33] ^ d1[33] ^ d2[33];
                        req_reg.mag_y <= m_y;
                        req_reg.go    <= 1'b1;
                        phase_reg     <= 1'b0;
                        state_reg     <= S_TWAIT;
                    end
                end
                S_TWAIT:
                begin
                    if (rsp.done)
                    begin
                        if (kind_reg[cur] == KIND_LINEAR)
                        begin
                            sum_reg[wcur] <= sum_reg[wcur] + 48'(signed'(e_y0)) + rv;
                            state_reg     <= S_NEXT;
                        end
                        else
                        begin
                            qacc_reg <= qacc_reg + rclamp;
                            sat_reg  <= sat_reg | rsat;
                            if (term_reg == 2'd2)
                            begin
                                state_reg <= S_QSUM;
                            end
                            else
                            begin
                                term_reg  <= term_reg + 2'd1;
                                state_reg <= S_TERM;
                            end
                        end
                    end
                end
                S_QSUM:
                begin
                    sum_reg[wcur] <= sum_reg[wcur] + qclamp;
                    sat_reg       <= sat_reg | qsat;
                    state_reg     <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (idx_reg == CntW'(MAX_ENTRIES - 1))
                    begin
                        term_reg  <= '0;
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CntW'(1);
                        state_reg <= S_READ;
                    end
                end
                S_FINAL:
                begin
                    vel_reg[fin_w] <= fin_c;
                    sat_reg        <= sat_reg | fin_s;
                    if (term_reg == 2'd3)
                    begin
                        state_reg <= S_OUT;
                    end
                    term_reg <= term_reg + 2'd1;
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign vel_front_left  = vel_reg[0];
    assign vel_front_right = vel_reg[1];
    assign vel_rear_left   = vel_reg[2];
    assign vel_rear_right  = vel_reg[3];
    assign saturated       = sat_reg;

`ifndef SYNTHESIS
    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_OUT)
        else $error("result strobe without output step");
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != STATUS_TICK |-> !sat_reg && vel_reg[0] == 32'd0)
        else $error("load result carries velocity");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("busy while result shown");
`endif

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for piecewise_poly_wheel_profile_unit
// depends on ppwp_pkg and the unit itself; keeps its own copy of the entry table
module testbench;
    import ppwp_pkg::*;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam int TABLE_SLOTS = 16;
    localparam longint RATIO_CAP = longint'(1) << 40;
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct {
        logic        hold;
        logic        mode;
        logic [3:0]  slot;
        logic [1:0]  wheel;
        logic [1:0]  kind;
        logic        enable;
        logic [31:0] t_start;
        logic [31:0] t_end;
        logic [31:0] y_first;
        logic [31:0] y_last;
        logic [31:0] t_mid;
        logic [31:0] y_mid;
        logic [31:0] t_now;
    } cmd_t;

    typedef struct {
        status_t     status;
        logic [31:0] vel [4];
        logic        sat;
    } reply_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic        mode;
    logic [3:0]  slot;
    logic [1:0]  wheel_sel;
    logic [1:0]  curve_kind;
    logic        entry_enable;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] first_value;
    logic [31:0] last_value;
    logic [31:0] mid_time;
    logic [31:0] mid_value;
    logic [31:0] now_time;
    logic [1:0]  status;
    logic [31:0] vel_front_left;
    logic [31:0] vel_front_right;
    logic [31:0] vel_rear_left;
    logic [31:0] vel_rear_right;
    logic        saturated;

    piecewise_poly_wheel_profile_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .mode(mode), .slot(slot), .wheel_sel(wheel_sel), .curve_kind(curve_kind),
        .entry_enable(entry_enable), .start_time(start_time), .end_time(end_time),
        .first_value(first_value), .last_value(last_value), .mid_time(mid_time),
        .mid_value(mid_value), .now_time(now_time), .status(status),
        .vel_front_left(vel_front_left), .vel_front_right(vel_front_right),
        .vel_rear_left(vel_rear_left), .vel_rear_right(vel_rear_right),
        .saturated(saturated)
    );

    cmd_t   pending_cmds [$];
    reply_t expected_replies [$];
    int     error_count;
    longint cycle_count;
    int     gap_left;
    bit     no_gap_stretch;

    // shadow of the entry table
    logic        tbl_valid [TABLE_SLOTS];
    logic [1:0]  tbl_wheel [TABLE_SLOTS];
    kind_t       tbl_kind  [TABLE_SLOTS];
    logic [31:0] tbl_start [TABLE_SLOTS];
    logic [31:0] tbl_end   [TABLE_SLOTS];
    logic [31:0] tbl_first [TABLE_SLOTS];
    logic [31:0] tbl_last  [TABLE_SLOTS];
    logic [31:0] tbl_mid_t [TABLE_SLOTS];
    logic [31:0] tbl_mid_v [TABLE_SLOTS];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // append to the pending and expected queues
    task automatic queue_cmd(input cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic queue_reply(input reply_t r);
        expected_replies.insert(expected_replies.size(), r);
    endtask

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // y*n1*n2/(d1*d2) truncated toward zero, capped in magnitude
    function automatic longint scaled_ratio(input longint y, input longint n1, input longint n2,
                                            input longint d1, input longint d2);
        logic         neg;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [127:0] prod;
        logic [127:0] quot;
        longint       q;
        neg = (y < 0) ^ (n1 < 0) ^ (n2 < 0) ^ (d1 < 0) ^ (d2 < 0);
        num = magnitude(n1) * magnitude(n2);
        den = magnitude(d1) * magnitude(d2);
        if (den == 0)
            return 0;
        prod = {64'd0, num} * {64'd0, magnitude(y)};
        quot = prod / {64'd0, den};
        q = (quot > 128'(RATIO_CAP)) ? RATIO_CAP : longint'(quot[63:0]);
        return neg ? -q : q;
    endfunction

    function automatic longint clamp_int32(input longint v, inout logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint curve_value(input int i, input longint t, inout logic sat);
        longint t0;
        longint t1;
        longint tm;
        longint y0;
        longint y1;
        longint ym;
        longint a;
        longint b;
        longint c;
        t0 = longint'(tbl_start[i]);
        t1 = longint'(tbl_end[i]);
        tm = longint'(tbl_mid_t[i]);
        y0 = longint'(signed'(tbl_first[i]));
        y1 = longint'(signed'(tbl_last[i]));
        ym = longint'(signed'(tbl_mid_v[i]));
        case (tbl_kind[i])
            KIND_LINEAR: return y0 + scaled_ratio(y1 - y0, t - t0, 1, t1 - t0, 1);
            KIND_QUAD:
            begin
                a = clamp_int32(scaled_ratio(y0, t - tm, t - t1, t0 - tm, t0 - t1), sat);
                b = clamp_int32(scaled_ratio(ym, t - t0, t - t1, tm - t0, tm - t1), sat);
                c = clamp_int32(scaled_ratio(y1, t - t0, t - tm, t1 - t0, t1 - tm), sat);
                return clamp_int32(a + b + c, sat);
            end
            default: return y0;
        endcase
    endfunction

    // apply one transfer to the shadow table and return the reply it causes
    function automatic reply_t profile_step(input cmd_t c);
        reply_t r;
        longint sums [4];
        logic   sat;
        logic   store;
        sat = 1'b0;
        store = 1'b0;
        r.status = STATUS_STORED;
        for (int w = 0; w < 4; w++)
        begin
            sums[w] = 0;
            r.vel[w] = '0;
        end
        if (c.mode == MODE_TICK)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (tbl_valid[i] && c.t_now >= tbl_start[i] && c.t_now <= tbl_end[i])
                    sums[tbl_wheel[i]] += curve_value(i, longint'(c.t_now), sat);
            end
            for (int w = 0; w < 4; w++)
                r.vel[w] = 32'(clamp_int32(sums[w], sat));
            r.status = STATUS_TICK;
        end
        else
        begin
            if (c.enable)
            begin
                if (c.t_end <= c.t_start)
                    r.status = STATUS_BAD_END;
                else if (kind_t'(c.kind) == KIND_QUAD
                         && !(c.t_mid > c.t_start && c.t_mid < c.t_end))
                    r.status = STATUS_BAD_MID;
                else
                    store = 1'b1;
            end
            tbl_valid[c.slot] = store;
            if (store)
            begin
                tbl_wheel[c.slot] = c.wheel;
                tbl_kind[c.slot]  = kind_t'(c.kind);
                tbl_start[c.slot] = c.t_start;
                tbl_end[c.slot]   = c.t_end;
                tbl_first[c.slot] = c.y_first;
                tbl_last[c.slot]  = c.y_last;
                tbl_mid_t[c.slot] = c.t_mid;
                tbl_mid_v[c.slot] = c.y_mid;
            end
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic cmd_t load_cmd(input int s, input int w, input kind_t k, input bit en,
                                      input logic [31:0] t0, input logic [31:0] t1,
                                      input logic [31:0] y0, input logic [31:0] y1,
                                      input logic [31:0] tm, input logic [31:0] ym);
        cmd_t c;
        c.hold = 1'b0;
        c.mode = MODE_LOAD;
        c.slot = 4'(s);
        c.wheel = 2'(w);
        c.kind = k;
        c.enable = en;
        c.t_start = t0;
        c.t_end = t1;
        c.y_first = y0;
        c.y_last = y1;
        c.t_mid = tm;
        c.y_mid = ym;
        c.t_now = $urandom;
        return c;
    endfunction

    // tick with junk in every field it ignores
    function automatic cmd_t tick_cmd(input logic [31:0] t);
        cmd_t c;
        c = load_cmd($urandom_range(0, 15), $urandom_range(0, 3), kind_t'($urandom_range(0, 3)),
                     $urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        c.mode = MODE_TICK;
        c.t_now = t;
        return c;
    endfunction

    // time inside the busy window most of the time, anywhere otherwise
    function automatic logic [31:0] rand_time();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'h0001_0000 + $urandom_range(0, 32'h0008_0000);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_t random_cmd();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] tmp;
        logic [31:0] tm;
        kind_t k;
        cmd_t c;
        if ($urandom_range(0, 99) < 35)
            return tick_cmd(rand_time());
        a = rand_time();
        b = rand_time();
        if (a > b)
        begin
            tmp = a;
            a = b;
            b = tmp;
        end
        if (b - a < 2)
        begin
            if (a >= 2)
                a = a - 2;
            else
                b = a + 2;
        end
        tm = a + 1 + ($urandom % (b - a - 1));
        k = kind_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
        c = load_cmd($urandom_range(0, 15), $urandom_range(0, 3), k, 1'b1, a, b,
                     rand_value(), rand_value(), tm, rand_value());
        // malformed loads and clears
        case ($urandom_range(0, 19))
            0: c.enable = 1'b0;
            1: c.t_end = c.t_start - $urandom_range(0, 2);
            2: c.t_end = $urandom_range(0, 1) ? c.t_start : $urandom;
            3: c.t_mid = $urandom_range(0, 1) ? c.t_start
                         : ($urandom_range(0, 1) ? c.t_end : $urandom);
            default: ;
        endcase
        return c;
    endfunction

    // stimulus
    initial
    begin
        cmd_t c;
        error_count = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        queue_cmd(tick_cmd(32'h0000_0000));
        queue_cmd(load_cmd(0, 0, KIND_CONST, 1, 32'h0000_0000, 32'hFFFF_FFFF,
                           32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));
        queue_cmd(load_cmd(1, 0, KIND_SPARE, 1, 32'h0, 32'hFFFF_FFFF,
                           32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
        queue_cmd(load_cmd(2, 1, KIND_LINEAR, 1, 32'h0001_0000, 32'h0003_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        queue_cmd(load_cmd(3, 2, KIND_QUAD, 1, 32'h0001_0000, 32'h0001_0003,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0001,
                           32'h7FFF_FFFF));
        queue_cmd(load_cmd(4, 3, KIND_QUAD, 1, 32'h0000_0000, 32'hFFFF_FFFF,
                           32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000,
                           32'h0002_0000));
        queue_cmd(tick_cmd(32'h0001_0000));
        queue_cmd(tick_cmd(32'h0001_0002));
        queue_cmd(tick_cmd(32'h0002_0000));
        queue_cmd(tick_cmd(32'h0003_0000));
        queue_cmd(tick_cmd(32'hFFFF_FFFF));
        queue_cmd(tick_cmd(32'h4000_0000));
        // bad end, equal and reversed
        queue_cmd(load_cmd(5, 0, KIND_LINEAR, 1, 32'h5, 32'h5, 32'h1, 32'h2,
                           32'h0, 32'h0));
        queue_cmd(load_cmd(0, 0, KIND_CONST, 1, 32'hFFFF_FFFF, 32'h0, 32'h1,
                           32'h0, 32'h0, 32'h0));
        // bad midpoint at each edge
        queue_cmd(load_cmd(6, 1, KIND_QUAD, 1, 32'h10, 32'h20, 32'h1, 32'h2,
                           32'h10, 32'h3));
        queue_cmd(load_cmd(7, 1, KIND_QUAD, 1, 32'h10, 32'h20, 32'h1, 32'h2,
                           32'h20, 32'h3));
        // clear with garbage fields
        queue_cmd(load_cmd(1, 3, KIND_QUAD, 0, 32'h9, 32'h1, 32'h1, 32'h2,
                           32'h0, 32'h3));
        queue_cmd(load_cmd(15, 3, KIND_LINEAR, 1, 32'h0, 32'hFFFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        queue_cmd(load_cmd(14, 3, KIND_CONST, 1, 32'h0, 32'hFFFF_FFFF,
                           32'h8000_0000, 32'h0, 32'h0, 32'h0));
        queue_cmd(tick_cmd(32'h0001_0001));
        c = tick_cmd(32'hFFFF_FFFE);
        c.hold = 1'b1;
        queue_cmd(c);

        // random part
        for (int n = 0; n < 560; n++)
        begin
            c = random_cmd();
            if (n % 150 == 75)
                c.hold = 1'b1;
            queue_cmd(c);
        end

        while (pending_cmds.size() != 0 || start || expected_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // driver
    always @(posedge clk)
    begin
        cmd_t c;
        if (!rst_n)
        begin
            start <= 1'b0;
            mode <= MODE_LOAD;
            slot <= '0;
            wheel_sel <= '0;
            curve_kind <= '0;
            entry_enable <= 1'b0;
            start_time <= '0;
            end_time <= '0;
            first_value <= '0;
            last_value <= '0;
            mid_time <= '0;
            mid_value <= '0;
            now_time <= '0;
            gap_left <= 0;
            no_gap_stretch <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                c.hold = 1'b0;
                c.mode = mode;
                c.slot = slot;
                c.wheel = wheel_sel;
                c.kind = curve_kind;
                c.enable = entry_enable;
                c.t_start = start_time;
                c.t_end = end_time;
                c.y_first = first_value;
                c.y_last = last_value;
                c.t_mid = mid_time;
                c.y_mid = mid_value;
                c.t_now = now_time;
                queue_reply(profile_step(c));
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() != 0
                         && !(pending_cmds[0].hold
                              && (expected_replies.size() != 0 || start)))
                begin
                    c = pending_cmds.pop_front();
                    mode <= c.mode;
                    slot <= c.slot;
                    wheel_sel <= c.wheel;
                    curve_kind <= c.kind;
                    entry_enable <= c.enable;
                    start_time <= c.t_start;
                    end_time <= c.t_end;
                    first_value <= c.y_first;
                    last_value <= c.y_last;
                    mid_time <= c.t_mid;
                    mid_value <= c.y_mid;
                    now_time <= c.t_now;
                    start <= 1'b1;
                    if ($urandom_range(0, 29) == 0)
                        no_gap_stretch <= ~no_gap_stretch;
                    gap_left <= no_gap_stretch ? 0 : $urandom_range(0, 10);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        reply_t want;
        logic [31:0] got_vel [4];
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                report("unexpected result", 32'(status), 32'd0);
            end
            else
            begin
                want = expected_replies.pop_front();
                got_vel[0] = vel_front_left;
                got_vel[1] = vel_front_right;
                got_vel[2] = vel_rear_left;
                got_vel[3] = vel_rear_right;
                if (status !== want.status)
                    report("status", 32'(status), 32'(want.status));
                for (int w = 0; w < 4; w++)
                begin
                    if (got_vel[w] !== want.vel[w])
                        report($sformatf("velocity of wheel %0d", w), got_vel[w], want.vel[w]);
                end
                if (saturated !== want.sat)
                    report("saturated", 32'(saturated), 32'(want.sat));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
            tbl_valid[i] = 1'b0;
    end

endmodule
